FILE: sv/signal_observation_tracker_unit_macros.svh
// assertion macros shared by the tracker rtl
`ifndef SIGNAL_OBSERVATION_TRACKER_UNIT_MACROS_SVH
`define SIGNAL_OBSERVATION_TRACKER_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SOT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SOT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sot_pkg.sv
// shared types and constants of the signal observation tracker
`default_nettype none

package sot_pkg;

    localparam int ADDR_W = 48;
    localparam int STR_W  = 8;
    localparam int CH_W   = 8;
    localparam int CNT_W  = 13;
    localparam int RANK_W = 5;
    localparam int CTR_W  = 32;

    localparam logic KIND_WIFI = 1'b0;
    localparam logic KIND_BLE  = 1'b1;

    localparam logic signed [STR_W-1:0] EMPTY_STR_RESET = 8'sh80;

    typedef struct packed {
        logic                    radio_kind;
        logic [ADDR_W-1:0]       address;
        logic signed [STR_W-1:0] signal_strength;
        logic [CH_W-1:0]         channel;
        logic                    name_hidden;
        logic                    auth_open;
    } t_obs_item;

    typedef struct packed {
        logic                    first_seen;
        logic                    set_full;
        logic [CNT_W-1:0]        unique_total;
        logic [RANK_W-1:0]       top_rank;
        logic [CTR_W-1:0]        row_total;
        logic [CTR_W-1:0]        hidden_total;
        logic [CTR_W-1:0]        open_total;
        logic [CTR_W-1:0]        secured_total;
        logic [ADDR_W-1:0]       strongest_address;
        logic signed [STR_W-1:0] strongest_strength;
    } t_obs_result;

    typedef struct packed {
        logic load;
        logic scan;
        logic eval;
        logic apply;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic hit;
        logic scan_end;
    } t_ctrl_stat;

endpackage

`default_nettype wire

FILE: sv/sot_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module sot_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/sot_ctrl.sv
// sequencer for one observation: scan, evaluate, apply, emit
`default_nettype none

module sot_ctrl
    import sot_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_ctrl_stat i_stat,
    output t_ctrl_cmd       o_cmd,
    output logic            o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_APPLY,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.hit || i_stat.scan_end) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL:  n_state = S_APPLY;
            S_APPLY: n_state = S_EMIT;
            S_EMIT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd.load  = (r_state == S_IDLE) && i_start;
    assign o_cmd.scan  = (r_state == S_SCAN);
    assign o_cmd.eval  = (r_state == S_EVAL);
    assign o_cmd.apply = (r_state == S_APPLY);
    assign o_cmd.emit  = (r_state == S_EMIT);
    assign o_busy      = r_busy;

endmodule

`default_nettype wire

FILE: sv/sot_dp.sv
// datapath: seen stores, top lists, counters and result register
`default_nettype none

module sot_dp
    import sot_pkg::*;
#(
    parameter int WIFI_SEEN_DEPTH = 256,
    parameter int BLE_SEEN_DEPTH  = 256,
    parameter int TOP_DEPTH       = 4
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic signed [STR_W-1:0] i_cfg_wdata,
    input  wire t_obs_item               i_item,
    input  wire t_ctrl_cmd               i_cmd,
    output t_ctrl_stat                   o_stat,
    output t_obs_result                  o_result,
    output logic                         o_result_valid
);

    localparam int WAW = (WIFI_SEEN_DEPTH > 1) ? $clog2(WIFI_SEEN_DEPTH) : 1;
    localparam int BAW = (BLE_SEEN_DEPTH > 1) ? $clog2(BLE_SEEN_DEPTH) : 1;
    localparam int TIW = $clog2(TOP_DEPTH);
    localparam logic [CNT_W-1:0] WIFI_LIM = CNT_W'(WIFI_SEEN_DEPTH);
    localparam logic [CNT_W-1:0] BLE_LIM  = CNT_W'(BLE_SEEN_DEPTH);

    t_obs_item               r_item;
    logic signed [STR_W-1:0] r_empty;
    logic [CNT_W-1:0]        r_idx;
    logic                    r_pend;
    logic                    r_found;
    logic                    r_first;
    logic                    r_full;
    logic [RANK_W-1:0]       r_rank;
    logic [CNT_W-1:0]        r_cnt_wifi;
    logic [CNT_W-1:0]        r_cnt_ble;
    logic [CTR_W-1:0]        r_rows_wifi;
    logic [CTR_W-1:0]        r_rows_ble;
    logic [CTR_W-1:0]        r_hidden;
    logic [CTR_W-1:0]        r_open;
    logic [CTR_W-1:0]        r_secured;

    logic [ADDR_W-1:0]       r_slot_addr [2][TOP_DEPTH];
    logic signed [STR_W-1:0] r_slot_str  [2][TOP_DEPTH];
    logic [CH_W-1:0]         r_slot_ch   [2][TOP_DEPTH];
    logic                    r_slot_used [2][TOP_DEPTH];

    logic [TOP_DEPTH-1:0]    r_match_vec;
    logic [TOP_DEPTH-1:0]    r_gt_vec;

    t_obs_result             r_result;
    logic                    r_result_valid;

    logic                    kind;
    logic [CNT_W-1:0]        cur_cnt;
    logic [CNT_W-1:0]        cur_lim;
    logic [ADDR_W-1:0]       wifi_rdata;
    logic [ADDR_W-1:0]       ble_rdata;
    logic [ADDR_W-1:0]       rd_data;
    logic                    issue;
    logic                    hit;
    logic                    wifi_we;
    logic                    ble_we;
    logic                    is_new;
    logic signed [STR_W-1:0] obs_str;
    logic [CH_W-1:0]         obs_ch;

    logic [ADDR_W-1:0]       cur_addr [TOP_DEPTH];
    logic signed [STR_W-1:0] cur_str  [TOP_DEPTH];
    logic                    cur_used [TOP_DEPTH];
    logic [TOP_DEPTH-1:0]    match_vec;
    logic [TOP_DEPTH-1:0]    gt_vec;

    logic                    m_any;
    logic [TIW-1:0]          m_idx;
    logic                    g_any;
    logic [TIW-1:0]          g_idx;

    assign kind    = r_item.radio_kind;
    assign cur_cnt = (kind == KIND_BLE) ? r_cnt_ble : r_cnt_wifi;
    assign cur_lim = (kind == KIND_BLE) ? BLE_LIM : WIFI_LIM;
    assign rd_data = (kind == KIND_BLE) ? ble_rdata : wifi_rdata;
    assign obs_str = r_item.signal_strength;
    assign obs_ch  = (kind == KIND_BLE) ? '0 : r_item.channel;

    // scan pipeline: one read issued per cycle, compared in the cycle after
    assign issue = i_cmd.scan && (r_idx < cur_cnt);
    assign hit   = r_pend && (rd_data == r_item.address);

    assign o_stat.hit      = hit;
    assign o_stat.scan_end = !r_pend && !(r_idx < cur_cnt);

    assign is_new  = !r_found && (cur_cnt < cur_lim);
    assign wifi_we = i_cmd.apply && is_new && (kind == KIND_WIFI);
    assign ble_we  = i_cmd.apply && is_new && (kind == KIND_BLE);

    sot_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (WIFI_SEEN_DEPTH)
    ) u_wifi_seen (
        .i_clk   (i_clk),
        .i_we    (wifi_we),
        .i_waddr (r_cnt_wifi[WAW-1:0]),
        .i_wdata (r_item.address),
        .i_raddr (r_idx[WAW-1:0]),
        .o_rdata (wifi_rdata)
    );

    sot_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (BLE_SEEN_DEPTH)
    ) u_ble_seen (
        .i_clk   (i_clk),
        .i_we    (ble_we),
        .i_waddr (r_cnt_ble[BAW-1:0]),
        .i_wdata (r_item.address),
        .i_raddr (r_idx[BAW-1:0]),
        .o_rdata (ble_rdata)
    );

    // top list of the current kind, slot by slot
    always_comb begin
        for (int j = 0; j < TOP_DEPTH; j++) begin
            cur_addr[j] = (kind == KIND_BLE) ? r_slot_addr[1][j] : r_slot_addr[0][j];
            cur_str[j]  = (kind == KIND_BLE) ? r_slot_str[1][j]  : r_slot_str[0][j];
            cur_used[j] = (kind == KIND_BLE) ? r_slot_used[1][j] : r_slot_used[0][j];
            match_vec[j] = cur_used[j] && (cur_addr[j] == r_item.address);
            gt_vec[j]    = cur_used[j] ? (obs_str > cur_str[j]) : (obs_str > r_empty);
        end
    end

    // lowest matching slot wins
    always_comb begin
        m_any = 1'b0;
        m_idx = '0;
        g_any = 1'b0;
        g_idx = '0;
        for (int j = TOP_DEPTH - 1; j >= 0; j--) begin
            if (r_match_vec[j]) begin
                m_any = 1'b1;
                m_idx = TIW'(j);
            end
            if (r_gt_vec[j]) begin
                g_any = 1'b1;
                g_idx = TIW'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty     <= EMPTY_STR_RESET;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_cnt_wifi  <= '0;
            r_cnt_ble   <= '0;
            r_rows_wifi <= '0;
            r_rows_ble  <= '0;
            r_hidden    <= '0;
            r_open      <= '0;
            r_secured   <= '0;
            for (int kk = 0; kk < 2; kk++) begin
                for (int j = 0; j < TOP_DEPTH; j++) begin
                    r_slot_used[kk][j] <= 1'b0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                r_empty <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.scan) begin
                r_pend <= issue;
                if (issue) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.apply) begin
                if (wifi_we) begin
                    r_cnt_wifi <= r_cnt_wifi + 1'b1;
                end
                if (ble_we) begin
                    r_cnt_ble <= r_cnt_ble + 1'b1;
                end
                if (kind == KIND_BLE) begin
                    r_rows_ble <= r_rows_ble + 1'b1;
                end else begin
                    r_rows_wifi <= r_rows_wifi + 1'b1;
                    if (r_item.name_hidden) begin
                        r_hidden <= r_hidden + 1'b1;
                    end
                    if (r_item.auth_open) begin
                        r_open <= r_open + 1'b1;
                    end else begin
                        r_secured <= r_secured + 1'b1;
                    end
                end
                // insertion shifts weaker slots down, the last drops out
                for (int kk = 0; kk < 2; kk++) begin
                    if (kk == int'(kind) && !m_any && g_any) begin
                        for (int j = 1; j < TOP_DEPTH; j++) begin
                            if (TIW'(j) > g_idx) begin
                                r_slot_used[kk][j] <= r_slot_used[kk][j-1];
                            end
                        end
                        for (int j = 0; j < TOP_DEPTH; j++) begin
                            if (TIW'(j) == g_idx) begin
                                r_slot_used[kk][j] <= 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.scan) begin
            r_found <= hit;
        end
        if (i_cmd.eval) begin
            r_match_vec <= match_vec;
            r_gt_vec    <= gt_vec;
        end
        if (i_cmd.apply) begin
            r_first <= is_new;
            r_full  <= !r_found && !(cur_cnt < cur_lim);
            if (m_any) begin
                r_rank <= RANK_W'(m_idx);
            end else if (g_any) begin
                r_rank <= RANK_W'(g_idx);
            end else begin
                r_rank <= RANK_W'(TOP_DEPTH);
            end
            for (int kk = 0; kk < 2; kk++) begin
                if (kk == int'(kind)) begin
                    if (m_any) begin
                        // known address: overwrite in place, no re-sort
                        for (int j = 0; j < TOP_DEPTH; j++) begin
                            if (TIW'(j) == m_idx) begin
                                r_slot_str[kk][j] <= obs_str;
                                r_slot_ch[kk][j]  <= obs_ch;
                            end
                        end
                    end else if (g_any) begin
                        for (int j = 1; j < TOP_DEPTH; j++) begin
                            if (TIW'(j) > g_idx) begin
                                r_slot_addr[kk][j] <= r_slot_addr[kk][j-1];
                                r_slot_str[kk][j]  <= r_slot_str[kk][j-1];
                                r_slot_ch[kk][j]   <= r_slot_ch[kk][j-1];
                            end
                        end
                        for (int j = 0; j < TOP_DEPTH; j++) begin
                            if (TIW'(j) == g_idx) begin
                                r_slot_addr[kk][j] <= r_item.address;
                                r_slot_str[kk][j]  <= obs_str;
                                r_slot_ch[kk][j]   <= obs_ch;
                            end
                        end
                    end
                end
            end
        end
        if (i_cmd.emit) begin
            r_result.first_seen    <= r_first;
            r_result.set_full      <= r_full;
            r_result.unique_total  <= cur_cnt;
            r_result.top_rank      <= r_rank;
            r_result.row_total     <= (kind == KIND_BLE) ? r_rows_ble : r_rows_wifi;
            r_result.hidden_total  <= r_hidden;
            r_result.open_total    <= r_open;
            r_result.secured_total <= r_secured;
            if (cur_used[0]) begin
                r_result.strongest_address  <= cur_addr[0];
                r_result.strongest_strength <= cur_str[0];
            end else begin
                r_result.strongest_address  <= '0;
                r_result.strongest_strength <= r_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= i_cmd.emit;
        end
    end

    assign o_result       = r_result;
    assign o_result_valid = r_result_valid;

endmodule

`default_nettype wire

FILE: sv/signal_observation_tracker_unit.sv
// top level of the signal observation tracker
// usage:
//   items enter on start/i_item; an item is taken at a clock edge where start is
//   high and busy is low. busy stays high until the item's result has been
//   registered, so only one item is in work at a time.
//   each item yields exactly one result, shown on o_result for one cycle with
//   o_result_valid high; the receiver cannot stall, so it must take it then.
//   the user must write the single register (empty top-slot strength), via
//   i_cfg_we/i_cfg_wdata, only while busy is low; the block does not enforce it.
// sequence:
//   the seen set of the item's kind is searched one entry per cycle through the
//   registered read port of its ram, ending early on a hit. the item is then
//   compared against the top list, state is updated and the result is built;
//   the next item can be taken in the cycle the strobe is shown.
// reset:
//   synchronous, active low. counters, seen counts and top-list used bits clear,
//   the empty-slot strength returns to -128; seen ram contents are not cleared,
//   entries at or above the count are never read.
`default_nettype none
`include "signal_observation_tracker_unit_macros.svh"

module signal_observation_tracker_unit
    import sot_pkg::*;
#(
    parameter int WIFI_SEEN_DEPTH = 256,
    parameter int BLE_SEEN_DEPTH  = 256,
    parameter int TOP_DEPTH       = 4
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // item channel
    input  wire logic                    start,
    output logic                         busy,
    input  wire t_obs_item               i_item,
    // configuration write port
    input  wire logic                    i_cfg_we,
    input  wire logic signed [STR_W-1:0] i_cfg_wdata,
    // result channel
    output logic                         o_result_valid,
    output t_obs_result                  o_result
);

    // command and status between sequencer and datapath
    t_ctrl_cmd  cmd;
    t_ctrl_stat stat;

    // sequencer: idle, scan, eval, apply, emit
    sot_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath with both seen rams, both top lists and the counters
    sot_dp #(
        .WIFI_SEEN_DEPTH (WIFI_SEEN_DEPTH),
        .BLE_SEEN_DEPTH  (BLE_SEEN_DEPTH),
        .TOP_DEPTH       (TOP_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_item         (i_item),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

    // an accepted item keeps the block busy
    `SOT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    // one item gives one strobe
    `SOT_ASSERT_NEXT(a_one_strobe, o_result_valid, !o_result_valid, "result strobe repeated")
    // a result is never both newly stored and rejected as full
    `SOT_ASSERT_NOW(a_seen_flags, o_result_valid,
                    !(o_result.first_seen && o_result.set_full),
                    "first_seen and set_full both set")
    // rank stays within the list or marks not placed
    `SOT_ASSERT_NOW(a_rank_range, o_result_valid,
                    o_result.top_rank <= RANK_W'(TOP_DEPTH),
                    "top_rank beyond list depth")

endmodule

`default_nettype wire
